[hw/rtl/qcrm_pkg.sv]
// Package for the quaternion chain to rotation matrix core.
// Default word format, controller state codes and the command bundle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package qcrm_pkg;

  localparam int WORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF = 14;
  localparam int STEP_BITS     = 2;

  typedef enum logic [11:0] {
    ST_IDLE = 12'b0000_0000_0001,
    ST_H0   = 12'b0000_0000_0010,
    ST_H1   = 12'b0000_0000_0100,
    ST_H2   = 12'b0000_0000_1000,
    ST_H3   = 12'b0000_0001_0000,
    ST_H4   = 12'b0000_0010_0000,
    ST_HW   = 12'b0000_0100_0000,
    ST_M0   = 12'b0000_1000_0000,
    ST_M1   = 12'b0001_0000_0000,
    ST_M2   = 12'b0010_0000_0000,
    ST_M3   = 12'b0100_0000_0000,
    ST_MC   = 12'b1000_0000_0000
  } state_t;

  typedef struct packed {
    logic                 cap;        // accepted request: capture input
    logic                 mul_en;     // issue one multiplier step
    logic                 mul_mat;    // 1: matrix terms, 0: Hamilton terms
    logic [STEP_BITS-1:0] mul_step;
    logic                 ham_write;  // saturate sums into accumulator
    logic                 mat_write;  // combine matrix, load output register
  } cmd_t;

endpackage
`default_nettype wire

[hw/rtl/qcrm_ctrl.sv]
// Controller for the quaternion chain core: sequences capture, the four
// multiplier steps, accumulator write and matrix output. Uses qcrm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qcrm_ctrl
  import qcrm_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_tvalid,
  output logic in_tready,
  input  wire  in_start,
  input  wire  in_last,
  input  wire  out_free,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.cap  = 1'b1;
          last_nxt = in_last;
          if (in_start) state_nxt = in_last ? ST_M0 : ST_IDLE;
          else          state_nxt = ST_H0;
        end
      end
      ST_H0: begin
        cmd.mul_en = 1'b1; cmd.mul_step = 2'd0; state_nxt = ST_H1;
      end
      ST_H1: begin
        cmd.mul_en = 1'b1; cmd.mul_step = 2'd1; state_nxt = ST_H2;
      end
      ST_H2: begin
        cmd.mul_en = 1'b1; cmd.mul_step = 2'd2; state_nxt = ST_H3;
      end
      ST_H3: begin
        cmd.mul_en = 1'b1; cmd.mul_step = 2'd3; state_nxt = ST_H4;
      end
      ST_H4: state_nxt = ST_HW;
      ST_HW: begin
        cmd.ham_write = 1'b1;
        state_nxt     = last_r ? ST_M0 : ST_IDLE;
      end
      ST_M0: begin
        cmd.mul_en = 1'b1; cmd.mul_mat = 1'b1; cmd.mul_step = 2'd0; state_nxt = ST_M1;
      end
      ST_M1: begin
        cmd.mul_en = 1'b1; cmd.mul_mat = 1'b1; cmd.mul_step = 2'd1; state_nxt = ST_M2;
      end
      ST_M2: begin
        cmd.mul_en = 1'b1; cmd.mul_mat = 1'b1; cmd.mul_step = 2'd2; state_nxt = ST_M3;
      end
      ST_M3: state_nxt = ST_MC;
      ST_MC: begin
        if (out_free) begin
          cmd.mat_write = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.cap, cmd.mul_en, cmd.ham_write, cmd.mat_write}))
    else $error("more than one datapath command in a cycle");

  a_hw_after_h4: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HW) |-> ($past(state_r) == ST_H4))
    else $error("accumulator write without drained term stage");

  a_mul_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_tvalid && !in_start) |=> (state_r == ST_H0))
    else $error("multiply request did not start the product sequence");

endmodule
`default_nettype wire

[hw/rtl/qcrm_dp.sv]
// Datapath for the quaternion chain core: accumulator, four shared
// multipliers, rounding/sum stage, matrix combine and output register.
// Uses qcrm_pkg; driven by qcrm_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module qcrm_dp
  import qcrm_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int IN_BITS  = ((4 * WORD_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = ((9 * WORD_BITS + 7) / 8) * 8
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire  [IN_BITS-1:0]  in_tdata,
  input  wire                 in_start,
  input  cmd_t                cmd,
  output logic                out_free,
  output logic                out_tvalid,
  input  wire                 out_tready,
  output logic [OUT_BITS-1:0] out_tdata,
  output logic [0:0]          out_tuser
);

  localparam int W      = WORD_BITS;
  localparam int P_BITS = 2 * W;
  localparam int T_BITS = 2 * W - FRAC_BITS + 2;
  localparam int S_BITS = T_BITS + 2;
  localparam int HALF_H = 1 << (FRAC_BITS - 1);
  localparam int HALF_M = 1 << (FRAC_BITS - 2);

  localparam logic [W-1:0] ONE_W = W'(1) << FRAC_BITS;
  localparam logic signed [S_BITS-1:0] ONE_S = S_BITS'(1) << FRAC_BITS;
  localparam logic signed [S_BITS-1:0] SMAX  = S_BITS'({1'b0, {(W-1){1'b1}}});
  localparam logic signed [S_BITS-1:0] SMIN  =
    S_BITS'(signed'({1'b1, {(W-1){1'b0}}}));

  typedef struct packed {
    logic                 en;
    logic                 mat;
    logic [STEP_BITS-1:0] step;
    logic [3:0]           neg;
  } term_ctl_t;

  logic signed [W-1:0]      acc_r [4];
  logic signed [W-1:0]      q_r   [4];
  logic signed [P_BITS-1:0] p_r   [4];
  logic signed [S_BITS-1:0] sum_r [4];
  logic signed [T_BITS-1:0] t_r   [9];
  term_ctl_t                tc_r;
  logic                     sticky_r;
  logic                     out_tvalid_r;
  logic [9*W-1:0]           out_data_r;
  logic                     out_flag_r;

  logic signed [W-1:0]      opa [4];
  logic signed [W-1:0]      opb [4];
  logic [3:0]               neg;
  logic signed [T_BITS-1:0] term [4];
  logic signed [S_BITS-1:0] e [9];
  logic signed [S_BITS-1:0] m [9];
  logic [8:0]               m_ov;
  logic [3:0]               h_ov;
  logic [9*W-1:0]           m_pack;

  function automatic logic signed [W-1:0] sat_w(input logic signed [S_BITS-1:0] v);
    if (v > SMAX)      sat_w = W'(SMAX);
    else if (v < SMIN) sat_w = W'(SMIN);
    else               sat_w = W'(v);
  endfunction

  function automatic logic sat_ov(input logic signed [S_BITS-1:0] v);
    sat_ov = (v > SMAX) || (v < SMIN);
  endfunction

  // operand select: lane j builds term k of component j (s, x, y, z)
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      opa[j] = '0;
      opb[j] = '0;
    end
    neg = 4'b0000;
    if (!cmd.mul_mat) begin
      case (cmd.mul_step)
        2'd0: begin
          opa[0] = acc_r[0]; opb[0] = q_r[0];
          opa[1] = acc_r[2]; opb[1] = q_r[3];
          opa[2] = acc_r[3]; opb[2] = q_r[1];
          opa[3] = acc_r[1]; opb[3] = q_r[2];
        end
        2'd1: begin
          opa[0] = acc_r[1]; opb[0] = q_r[1];
          opa[1] = acc_r[3]; opb[1] = q_r[2];
          opa[2] = acc_r[1]; opb[2] = q_r[3];
          opa[3] = acc_r[2]; opb[3] = q_r[1];
          neg    = 4'b1111;
        end
        2'd2: begin
          opa[0] = acc_r[2]; opb[0] = q_r[2];
          opa[1] = acc_r[0]; opb[1] = q_r[1];
          opa[2] = acc_r[0]; opb[2] = q_r[2];
          opa[3] = acc_r[0]; opb[3] = q_r[3];
          neg    = 4'b0001;
        end
        default: begin
          opa[0] = acc_r[3]; opb[0] = q_r[3];
          opa[1] = q_r[0];   opb[1] = acc_r[1];
          opa[2] = q_r[0];   opb[2] = acc_r[2];
          opa[3] = q_r[0];   opb[3] = acc_r[3];
          neg    = 4'b0001;
        end
      endcase
    end else begin
      // term slots: xx xy xz yy | yz zz sx sy | sz
      case (cmd.mul_step)
        2'd0: begin
          opa[0] = acc_r[1]; opb[0] = acc_r[1];
          opa[1] = acc_r[1]; opb[1] = acc_r[2];
          opa[2] = acc_r[1]; opb[2] = acc_r[3];
          opa[3] = acc_r[2]; opb[3] = acc_r[2];
        end
        2'd1: begin
          opa[0] = acc_r[2]; opb[0] = acc_r[3];
          opa[1] = acc_r[3]; opb[1] = acc_r[3];
          opa[2] = acc_r[0]; opb[2] = acc_r[1];
          opa[3] = acc_r[0]; opb[3] = acc_r[2];
        end
        2'd2: begin
          opa[0] = acc_r[0]; opb[0] = acc_r[3];
        end
        default: begin
          opa[0] = '0; opb[0] = '0;
        end
      endcase
    end
  end

  // round half up: add half an LSB, arithmetic shift
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      logic signed [P_BITS:0]   rh;
      logic signed [P_BITS:0]   rm;
      logic signed [T_BITS-1:0] tv;
      rh = (P_BITS+1)'(p_r[j]) + (P_BITS+1)'(HALF_H);
      rm = (P_BITS+1)'(p_r[j]) + (P_BITS+1)'(HALF_M);
      tv = tc_r.mat ? T_BITS'(rm >>> (FRAC_BITS - 1)) : T_BITS'(rh >>> FRAC_BITS);
      term[j] = tc_r.neg[j] ? -tv : tv;
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) e[k] = S_BITS'(t_r[k]);
    m[0] = ONE_S - (e[3] + e[5]);
    m[1] = e[1] + e[8];
    m[2] = e[2] - e[7];
    m[3] = e[1] - e[8];
    m[4] = ONE_S - (e[0] + e[5]);
    m[5] = e[4] + e[6];
    m[6] = e[2] + e[7];
    m[7] = e[4] - e[6];
    m[8] = ONE_S - (e[0] + e[3]);
    for (int k = 0; k < 9; k++) begin
      m_ov[k]             = sat_ov(m[k]);
      m_pack[k*W +: W]    = sat_w(m[k]);
    end
    for (int j = 0; j < 4; j++) h_ov[j] = sat_ov(sum_r[j]);
  end

  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_BITS'(out_data_r);
  assign out_tuser  = out_flag_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r[0]     <= ONE_W;
      for (int j = 1; j < 4; j++) acc_r[j] <= '0;
      sticky_r     <= 1'b0;
      tc_r         <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      tc_r.en   <= cmd.mul_en;
      tc_r.mat  <= cmd.mul_mat;
      tc_r.step <= cmd.mul_step;
      tc_r.neg  <= neg;
      if (cmd.cap && in_start) begin
        for (int j = 0; j < 4; j++) acc_r[j] <= in_tdata[j*W +: W];
        sticky_r <= 1'b0;
      end else if (cmd.ham_write) begin
        for (int j = 0; j < 4; j++) acc_r[j] <= sat_w(sum_r[j]);
        sticky_r <= sticky_r | (|h_ov);
      end else if (cmd.mat_write) begin
        sticky_r <= sticky_r | (|m_ov);
      end
      if (cmd.mat_write)   out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      for (int j = 0; j < 4; j++) q_r[j] <= in_tdata[j*W +: W];
    end
    if (cmd.mul_en) begin
      for (int j = 0; j < 4; j++) p_r[j] <= P_BITS'(opa[j]) * P_BITS'(opb[j]);
    end
    if (tc_r.en && !tc_r.mat) begin
      for (int j = 0; j < 4; j++)
        sum_r[j] <= ((tc_r.step == 2'd0) ? '0 : sum_r[j]) + S_BITS'(term[j]);
    end
    if (tc_r.en && tc_r.mat) begin
      for (int k = 0; k < 9; k++)
        if (tc_r.step == STEP_BITS'(k / 4)) t_r[k] <= term[k % 4];
    end
    if (cmd.mat_write) begin
      out_data_r <= m_pack;
      out_flag_r <= sticky_r | (|m_ov);
    end
  end

  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mat_write |-> out_free)
    else $error("matrix written over a pending result");

  a_out_set: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mat_write |=> out_tvalid_r)
    else $error("matrix write did not raise output valid");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cap && in_start) |=> !sticky_r)
    else $error("start request did not clear overflow flag");

endmodule
`default_nettype wire

[hw/rtl/quaternion_chain_to_rotation_matrix_core.sv]
// Top level of the quaternion chain to rotation matrix core.
// Instantiates qcrm_ctrl and qcrm_dp; uses qcrm_pkg.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tdata {s,x,y,z}, tuser start_chain, tlast last
//  out_    | out | out_tvalid/tready  | tdata 3x3 matrix, tuser overflow_flag
//
// A start item without last is only captured. A multiply item runs four steps
// of the four shared multipliers, a rounding/sum stage and accumulator write.
// The last item adds three multiplier steps, a drain and the matrix combine.
// Synchronous active-low reset: identity accumulator, flag and output cleared.
// The next request is taken while a result waits; the matrix combine stalls
// only while the output register still holds an untaken result.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_chain_to_rotation_matrix_core
  import qcrm_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int IN_BITS  = ((4 * WORD_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = ((9 * WORD_BITS + 7) / 8) * 8
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  input  wire  [IN_BITS-1:0]  in_tdata,   // q_scalar, q_vec_x, q_vec_y, q_vec_z
  input  wire  [0:0]          in_tuser,   // start_chain
  input  wire                 in_tlast,   // last_in_chain
  output logic                out_tvalid,
  input  wire                 out_tready,
  output logic [OUT_BITS-1:0] out_tdata,  // m_r0_c0..m_r0_c2, m_r1_c0..m_r1_c2,
                                          // m_r2_c0..m_r2_c2
  output logic [0:0]          out_tuser   // overflow_flag
);

  cmd_t cmd;
  logic out_free;

  qcrm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_start  (in_tuser[0]),
    .in_last   (in_tlast),
    .out_free  (out_free),
    .cmd       (cmd)
  );

  qcrm_dp #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_start   (in_tuser[0]),
    .cmd        (cmd),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
